>>> rtl/signed_int_to_decimal_ascii_macros.svh
// assertion macros for the top-level rtl file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/sida_pkg.sv
// types and constants for the signed integer to decimal ascii converter
package sida_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ascii converter, top level.
//
// Input channel s_axis: one transaction carries one two's-complement integer
// of DATA_WIDTH bits. Output channel m_axis: the decimal text of that value,
// one ascii character per transaction, most significant first, with a
// leading '-' for negative values and no leading zeros; tlast marks the
// final character. Zero gives a single '0'.
// Per value: the value is taken, converted by bit-serial binary to bcd
// shifting and seen done, then leading zero digits are dropped one at a time
// (at most NUM_DIGITS-1) in the skip state, and then the characters follow,
// one character per cycle while the receiver does not stall.
// A new value is taken once the last character of the previous one sits in
// the output register. If the receiver stalls, the output register holds
// its character and the converter waits before loading the next one.
// Reset clears the control state and empties the output register.
module signed_int_to_decimal_ascii #(
  parameter  int DATA_WIDTH = 32,
  localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // character
  output logic               m_axis_tlast   // last
);

  `include "signed_int_to_decimal_ascii_macros.svh"

  localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  sida_pkg::state_t state, state_next;

  logic [DATA_WIDTH-1:0] value_in;
  logic [DATA_WIDTH-1:0] mag;
  logic                  negative;
  logic [REM_W-1:0]      remaining;
  logic                  dab_busy;
  logic [3:0]            top_digit;
  logic                  accept;
  logic                  out_free;
  logic                  dab_load;
  logic                  digit_shift;
  logic                  load_sign;
  logic                  load_digit;

  assign value_in = s_axis_tdata[DATA_WIDTH-1:0];
  assign mag      = value_in[DATA_WIDTH-1] ? (~value_in + DATA_WIDTH'(1)) : value_in;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  sida_dabble #(
    .DATA_WIDTH(DATA_WIDTH),
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .clk        (clk),
    .rst        (rst),
    .load       (dab_load),
    .mag        (mag),
    .digit_shift(digit_shift),
    .busy       (dab_busy),
    .top_digit  (top_digit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sida_pkg::ST_IDLE: begin
        if (accept) state_next = sida_pkg::ST_CONVERT;
      end
      sida_pkg::ST_CONVERT: begin
        if (!dab_busy) state_next = sida_pkg::ST_SKIP;
      end
      sida_pkg::ST_SKIP: begin
        if (top_digit != 4'd0 || remaining == REM_W'(1)) begin
          state_next = negative ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
        end
      end
      sida_pkg::ST_SIGN: begin
        if (out_free) state_next = sida_pkg::ST_DIGITS;
      end
      sida_pkg::ST_DIGITS: begin
        if (out_free && remaining == REM_W'(1)) state_next = sida_pkg::ST_IDLE;
      end
      default: state_next = sida_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    dab_load      = 1'b0;
    digit_shift   = 1'b0;
    load_sign     = 1'b0;
    load_digit    = 1'b0;
    case (state)
      sida_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        dab_load      = s_axis_tvalid;
      end
      sida_pkg::ST_SKIP: begin
        digit_shift = (top_digit == 4'd0) && (remaining != REM_W'(1));
      end
      sida_pkg::ST_SIGN: begin
        load_sign = out_free;
      end
      sida_pkg::ST_DIGITS: begin
        load_digit  = out_free;
        digit_shift = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= value_in[DATA_WIDTH-1];
    end
    if (state == sida_pkg::ST_CONVERT) begin
      remaining <= REM_W'(NUM_DIGITS);
    end else if (digit_shift) begin
      remaining <= remaining - REM_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_sign || load_digit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      m_axis_tdata <= sida_pkg::ASCII_MINUS;
      m_axis_tlast <= 1'b0;
    end else if (load_digit) begin
      m_axis_tdata <= sida_pkg::ASCII_ZERO + {4'd0, top_digit};
      m_axis_tlast <= (remaining == REM_W'(1));
    end
  end

  `SIDA_ASSERT_NOW(a_char_legal, clk, rst, m_axis_tvalid,
    m_axis_tdata == sida_pkg::ASCII_MINUS ||
    (m_axis_tdata >= sida_pkg::ASCII_ZERO && m_axis_tdata <= sida_pkg::ASCII_ZERO + 8'd9))
  `SIDA_ASSERT_NOW(a_minus_not_last, clk, rst,
    m_axis_tvalid && m_axis_tdata == sida_pkg::ASCII_MINUS, !m_axis_tlast)
  `SIDA_ASSERT_NEXT(a_accept_starts_conv, clk, rst, accept, dab_busy)
  `SIDA_ASSERT_NOW(a_digit_bcd, clk, rst, load_digit, top_digit <= 4'd9)
  `SIDA_ASSERT_NOW(a_remaining_nonzero, clk, rst,
    state == sida_pkg::ST_DIGITS || state == sida_pkg::ST_SKIP, remaining != '0)

endmodule

>>> rtl/sida_dabble.sv
// bit-serial binary to bcd converter with a digit shift-out port
module sida_dabble #(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [DATA_WIDTH-1:0] mag,
  input  logic                  digit_shift,
  output logic                  busy,
  output logic [3:0]            top_digit
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int BCD_W = 4 * NUM_DIGITS;

  logic [DATA_WIDTH-1:0] mag_sr;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic                  running;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + sida_pkg::BCD_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (load) begin
      running <= 1'b1;
      cnt     <= CNT_W'(DATA_WIDTH);
    end else if (running) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_sr <= mag;
      bcd    <= '0;
    end else if (running) begin
      mag_sr <= {mag_sr[DATA_WIDTH-2:0], 1'b0};
      bcd    <= {bcd_adj[BCD_W-2:0], mag_sr[DATA_WIDTH-1]};
    end else if (digit_shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign busy      = running;
  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

>>> tb/tb.sv
// testbench for the signed integer to decimal ascii converter
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 190;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  class decimal_text_board;
    text_char_t expected_chars[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_value(logic [31:0] value);
      logic [31:0] mag;
      logic [7:0] digits [10];
      int nd;
      text_char_t tc;
      nd = 0;
      mag = value[31] ? (~value + 32'd1) : value;
      if (mag == 0) begin
        digits[0] = sida_pkg::ASCII_ZERO;
        nd = 1;
      end
      while (mag != 0) begin
        digits[nd] = sida_pkg::ASCII_ZERO + 8'(mag % 10);
        mag = mag / 10;
        nd++;
      end
      if (value[31]) begin
        tc.character = sida_pkg::ASCII_MINUS;
        tc.last = 1'b0;
        expected_chars.push_back(tc);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        tc.character = digits[k];
        tc.last = (k == 0);
        expected_chars.push_back(tc);
      end
    endfunction

    function void check_char(logic [7:0] character, logic last);
      text_char_t tc;
      if (expected_chars.size() == 0) begin
        $error("character: none expected, actual %0d", character);
        errors++;
        return;
      end
      tc = expected_chars.pop_front();
      if (character !== tc.character) begin
        $error("character: expected %0d, actual %0d", tc.character, character);
        errors++;
      end
      if (last !== tc.last) begin
        $error("last: expected %0b, actual %0b", tc.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  decimal_text_board board;
  bit quiet;
  int cycles = 0;

  signed_int_to_decimal_ascii #(.DATA_WIDTH(32)) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_char(m_axis_tdata, m_axis_tlast);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_value(input logic [31:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = value;
    do @(posedge clk); while (!s_axis_tready);
    board.note_value(value);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] pow10;
    logic [31:0] v;
    pow10 = 32'd1;
    repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 2000) - 1000;
      2: v = pow10 + $urandom_range(0, 2) - 1;
      3: v = $urandom >> $urandom_range(0, 31);
      default: v = 32'h8000_0000 + $urandom_range(0, 3) - 2;
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000)
      v = ~v + 32'd1;
    return v;
  endfunction

  initial begin
    logic [31:0] directed [$];
    board = new();
    quiet = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, -32'sd1000000000, 32'd999999999, 32'h0000_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'd7, -32'sd5};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - 30) || ((i / 30) % 3 == 1);
      send_value(random_value());
    end
    s_axis_tvalid = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
